/* rtl/ebml_pkg.sv */
// ============================================================================
// EBML header parser package
// Result item layout, status codes and field length decoders.
// ============================================================================
package ebml_pkg;

    localparam int ID_W        = 32;
    localparam int ID_LEN_W    = 3;
    localparam int SIZE_W      = 56;
    localparam int SIZE_LEN_W  = 4;
    localparam int LEFT_W      = 4;
    localparam int OUT_DATA_W  = 96;
    localparam int OUT_USER_W  = 3;

    localparam logic [7:0]        SIZE_DATA_MASK    = 8'hFF;
    localparam logic [SIZE_W-1:0] UNKNOWN_SIZE_BITS = SIZE_W'(8'h7F);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ID    = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]       element_id;
        logic [ID_LEN_W-1:0]   id_bytes;
        logic [SIZE_W-1:0]     size_value;
        logic [SIZE_LEN_W-1:0] size_bytes;
        logic                  unknown_size;
        t_status               status;
    } t_result;

    // ID length from the leading bits of the first ID byte; zero when invalid
    function automatic logic [ID_LEN_W-1:0] id_len_of(input logic [7:0] b);
        logic [ID_LEN_W-1:0] len;
        len = '0;
        priority casez (b[7:4])
            4'b1???: len = 3'd1;
            4'b01??: len = 3'd2;
            4'b001?: len = 3'd3;
            4'b0001: len = 3'd4;
            default: len = '0;
        endcase
        return len;
    endfunction

    // Size length from the position of the first set bit; zero for 0x00
    function automatic logic [SIZE_LEN_W-1:0] size_len_of(input logic [7:0] b);
        logic [SIZE_LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                len = SIZE_LEN_W'(8 - i);
            end
        end
        return len;
    endfunction

endpackage

/* rtl/ebml_element_header_parser.sv */
// Each result item is registered before o_m_tvalid (into the skid entry if stalled).
// Throughput: one byte per clock while the skid entry is empty; the parse state is
// a single register stage fed by the byte-decode logic, and a two-entry output
// (register plus skid) keeps input accepted while one result waits downstream.
// Reset (i_rst_n low, synchronous): parser returns to the first ID byte and
// both output entries are emptied.
// ============================================================================
// EBML element header parser
// Parses element ID and size variable-length integers from a byte stream
// and emits one result item per header, bad first byte or truncation.
// ============================================================================
module ebml_element_header_parser
    import ebml_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,  // [7:0] stream_byte
    input  logic                  i_s_tlast,  // last_in_buffer
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [31:0] element_id, [34:32] id_bytes, [90:35] size_value,
    // [94:91] size_bytes, [95] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [OUT_USER_W-1:0] o_m_tuser   // [0] unknown_size, [2:1] status
);

    logic                  r_phase,    n_phase;
    logic [LEFT_W-1:0]     r_left,     n_left;
    logic [ID_W-1:0]       r_id,       n_id;
    logic [SIZE_W-1:0]     r_size,     n_size;
    logic [ID_LEN_W-1:0]   r_id_len,   n_id_len;
    logic [SIZE_LEN_W-1:0] r_size_len, n_size_len;

    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;

    logic    accept;
    logic    res_vld;
    t_result res;

    assign o_s_tready = !r_skid_vld;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        logic [7:0]            b;
        logic [ID_LEN_W-1:0]   id_len;
        logic [SIZE_LEN_W-1:0] sz_len;
        logic                  restart;
        b          = i_s_tdata;
        id_len     = id_len_of(b);
        sz_len     = size_len_of(b);
        restart    = 1'b0;
        n_phase    = r_phase;
        n_left     = r_left;
        n_id       = r_id;
        n_size     = r_size;
        n_id_len   = r_id_len;
        n_size_len = r_size_len;
        res_vld    = 1'b0;
        res        = '0;
        res.status = ST_OK;
        if (accept) begin
            if (!r_phase) begin
                if (r_left == '0 && id_len == '0) begin
                    res_vld    = 1'b1;
                    res.status = ST_BAD_ID;
                    restart    = 1'b1;
                end else begin
                    if (r_left == '0) begin
                        n_id     = {24'd0, b};
                        n_id_len = id_len;
                        n_left   = {1'b0, id_len - 3'd1};
                    end else begin
                        n_id   = {r_id[ID_W-9:0], b};
                        n_left = r_left - 4'd1;
                    end
                    n_phase = (n_left == '0);
                    if (i_s_tlast) begin
                        res_vld    = 1'b1;
                        res.status = ST_TRUNCATED;
                        if (n_phase) begin
                            res.element_id = n_id;
                            res.id_bytes   = n_id_len;
                        end
                        restart = 1'b1;
                    end
                end
            end else begin
                if (r_left == '0 && sz_len == '0) begin
                    res_vld        = 1'b1;
                    res.status     = ST_BAD_SIZE;
                    res.element_id = r_id;
                    res.id_bytes   = r_id_len;
                    restart        = 1'b1;
                end else begin
                    if (r_left == '0) begin
                        n_size     = {48'd0, b & (SIZE_DATA_MASK >> sz_len)};
                        n_size_len = sz_len;
                        n_left     = sz_len - 4'd1;
                    end else begin
                        n_size = {r_size[SIZE_W-9:0], b};
                        n_left = r_left - 4'd1;
                    end
                    if (n_left == '0) begin
                        // header complete: one-byte 0xFF means unknown size
                        res_vld         = 1'b1;
                        res.element_id  = r_id;
                        res.id_bytes    = r_id_len;
                        res.size_bytes  = n_size_len;
                        res.status      = ST_OK;
                        if (n_size_len == 4'd1 && n_size == UNKNOWN_SIZE_BITS) begin
                            res.unknown_size = 1'b1;
                        end else begin
                            res.size_value = n_size;
                        end
                        restart = 1'b1;
                    end else if (i_s_tlast) begin
                        res_vld        = 1'b1;
                        res.status     = ST_TRUNCATED;
                        res.element_id = r_id;
                        res.id_bytes   = r_id_len;
                        restart        = 1'b1;
                    end
                end
            end
        end
        if (restart) begin
            n_phase    = 1'b0;
            n_left     = '0;
            n_id       = '0;
            n_size     = '0;
            n_id_len   = '0;
            n_size_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 1'b0;
            r_left     <= '0;
            r_id       <= '0;
            r_size     <= '0;
            r_id_len   <= '0;
            r_size_len <= '0;
        end else begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_id       <= n_id;
            r_size     <= n_size;
            r_id_len   <= n_id_len;
            r_size_len <= n_size_len;
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_tready) begin
            r_out_vld  <= r_skid_vld || res_vld;
            r_skid_vld <= 1'b0;
        end else if (res_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_tready) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (res_vld) begin
            // hold the new item behind the stalled one
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out.size_bytes, r_out.size_value,
                         r_out.id_bytes, r_out.element_id};
    assign o_m_tuser  = {r_out.status, r_out.unknown_size};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry full while output register empty");

    a_no_res_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !res_vld)
        else $error("result produced with no free output entry");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 4'd7)
        else $error("byte count out of range");

    a_ok_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res.status == ST_OK) |-> (res.id_bytes != '0 && res.size_bytes != '0))
        else $error("header result without lengths");

    a_size_phase_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_id_len != '0 && r_left <= 4'd7))
        else $error("size phase entered without an ID");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// EBML element header parser testbench
// Feeds directed and random byte streams (well-formed headers, truncated and
// broken headers, noise) with random gaps and output stalls, predicts every
// result item in step with the accepted bytes and checks each one field by
// field.
// ============================================================================
module tb
    import ebml_pkg::*;
();

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } t_feed_byte;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;  // [7:0] stream_byte
    logic                  i_s_tlast  = 1'b0; // last_in_buffer
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [31:0] element_id, [34:32] id_bytes, [90:35] size_value,
    // [94:91] size_bytes, [95] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;        // [0] unknown_size, [2:1] status

    ebml_element_header_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_feed_byte byte_feed[$];
    t_result    expected_hdrs[$];
    bit         drain_next;
    int         n_issued;
    int         n_accepted;
    int         n_results;
    int         n_fail;
    int         n_status[4];
    int         n_unknown;

    // Shadow parser state
    bit                    in_size;
    logic [LEFT_W-1:0]     owed;
    logic [ID_W-1:0]       id_acc;
    logic [SIZE_W-1:0]     size_acc;
    logic [ID_LEN_W-1:0]   id_len;
    logic [SIZE_LEN_W-1:0] sz_len;

    task automatic clear_parse();
        in_size  = 1'b0;
        owed     = '0;
        id_acc   = '0;
        size_acc = '0;
        id_len   = '0;
        sz_len   = '0;
    endtask

    task automatic parse_ebml_byte(input logic [7:0] b, input logic last,
                                   output bit emit, output t_result r);
        logic [3:0] len;
        emit = 1'b0;
        r    = '0;
        if (!in_size) begin
            if (owed == 0) begin
                priority casez (b[7:4])
                    4'b1???: len = 4'd1;
                    4'b01??: len = 4'd2;
                    4'b001?: len = 4'd3;
                    4'b0001: len = 4'd4;
                    default: len = 4'd0;
                endcase
                if (len == 0) begin
                    // drop the byte, report it with all other fields zero
                    emit = 1'b1;
                    r.status = ST_BAD_ID;
                    clear_parse();
                    return;
                end
                id_acc = {24'd0, b};
                id_len = len[2:0];
                owed   = len - 4'd1;
            end else begin
                id_acc = {id_acc[23:0], b};
                owed   = owed - 4'd1;
            end
            if (owed == 0) in_size = 1'b1;
            if (last) begin
                emit = 1'b1;
                r.status = ST_TRUNCATED;
                if (in_size) begin
                    r.element_id = id_acc;
                    r.id_bytes   = id_len;
                end
                clear_parse();
            end
        end else begin
            if (owed == 0) begin
                len = 4'd0;
                for (int p = 7; p >= 0; p--) begin
                    if (b[p] && len == 0) len = 4'(8 - p);
                end
                if (len == 0) begin
                    emit = 1'b1;
                    r.status     = ST_BAD_SIZE;
                    r.element_id = id_acc;
                    r.id_bytes   = id_len;
                    clear_parse();
                    return;
                end
                size_acc = SIZE_W'(b & (8'hFF >> len));
                sz_len   = len;
                owed     = len - 4'd1;
            end else begin
                size_acc = {size_acc[47:0], b};
                owed     = owed - 4'd1;
            end
            if (owed == 0) begin
                emit = 1'b1;
                r.status      = ST_OK;
                r.element_id  = id_acc;
                r.id_bytes    = id_len;
                r.size_bytes  = sz_len;
                // only the single byte 0xFF means unknown size
                if (sz_len == 1 && size_acc == SIZE_W'(8'h7F)) r.unknown_size = 1'b1;
                else r.size_value = size_acc;
                clear_parse();
            end else if (last) begin
                emit = 1'b1;
                r.status     = ST_TRUNCATED;
                r.element_id = id_acc;
                r.id_bytes   = id_len;
                clear_parse();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic last);
        t_feed_byte f;
        f.data  = b;
        f.last  = last;
        f.drain = drain_next;
        drain_next = 1'b0;
        byte_feed.insert(byte_feed.size(), f);
    endtask

    function automatic logic [7:0] rnd_byte();
        unique case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Header with the given lengths; last rides on byte index cut (-1: none)
    task automatic add_header(input int ilen, input int slen, input bit unk,
                              input int cut, input bit bad_size);
        logic [7:0] hdr[12];
        int         total;
        hdr[0] = (8'h80 >> (ilen - 1)) | (rnd_byte() & (8'hFF >> ilen));
        for (int k = 1; k < ilen; k++) hdr[k] = rnd_byte();
        if (bad_size) begin
            hdr[ilen] = 8'h00;
            total = ilen + 1;
        end else begin
            hdr[ilen] = unk ? 8'hFF
                            : ((8'h80 >> (slen - 1)) | (rnd_byte() & (8'hFF >> slen)));
            for (int k = 1; k < slen; k++) hdr[ilen + k] = rnd_byte();
            total = ilen + slen;
        end
        if (cut >= 0 && cut < total) total = cut + 1;
        for (int k = 0; k < total; k++) add_byte(hdr[k], k == cut);
    endtask

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // ------------------------------------------------------------------
    // Driver: present bytes from the feed at the falling edge
    // ------------------------------------------------------------------
    int s_gap;
    bit s_calm;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (n_accepted != n_issued) begin
            // hold the item until taken
        end else if (s_gap > 0) begin
            i_s_tvalid <= 1'b0;
            s_gap = s_gap - 1;
        end else if (byte_feed.size() > 0 &&
                     !(byte_feed[0].drain && expected_hdrs.size() != 0)) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= byte_feed[0].data;
            i_s_tlast  <= byte_feed[0].last;
            void'(byte_feed.pop_front());
            n_issued = n_issued + 1;
            if ($urandom_range(0, 39) == 0) s_calm = !s_calm;
            s_gap = draw_wait(s_calm);
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Output stalls, drawn anew for every result item
    int m_stall;
    int m_seen;
    bit m_calm;

    always @(negedge i_clk) begin
        if (m_seen != n_results) begin
            m_seen = n_results;
            if ($urandom_range(0, 39) == 0) m_calm = !m_calm;
            m_stall = draw_wait(m_calm);
        end
        if (m_stall > 0) begin
            i_m_tready <= 1'b0;
            m_stall = m_stall - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict from the accepted byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        bit      emit;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.element_id   = o_m_tdata[31:0];
            got.id_bytes     = o_m_tdata[34:32];
            got.size_value   = o_m_tdata[90:35];
            got.size_bytes   = o_m_tdata[94:91];
            got.unknown_size = o_m_tuser[0];
            got.status       = t_status'(o_m_tuser[2:1]);
            n_results = n_results + 1;
            if (expected_hdrs.size() == 0) begin
                $error("unexpected result item: tdata=%h tuser=%h", o_m_tdata, o_m_tuser);
                n_fail++;
            end else begin
                want = expected_hdrs.pop_front();
                if (got.element_id !== want.element_id) begin
                    $error("element_id: expected %h, got %h", want.element_id, got.element_id);
                    n_fail++;
                end
                if (got.id_bytes !== want.id_bytes) begin
                    $error("id_bytes: expected %0d, got %0d", want.id_bytes, got.id_bytes);
                    n_fail++;
                end
                if (got.size_value !== want.size_value) begin
                    $error("size_value: expected %h, got %h", want.size_value, got.size_value);
                    n_fail++;
                end
                if (got.size_bytes !== want.size_bytes) begin
                    $error("size_bytes: expected %0d, got %0d",
                           want.size_bytes, got.size_bytes);
                    n_fail++;
                end
                if (got.unknown_size !== want.unknown_size) begin
                    $error("unknown_size: expected %b, got %b",
                           want.unknown_size, got.unknown_size);
                    n_fail++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %s, got %s",
                           want.status.name(), got.status.name());
                    n_fail++;
                end
                if (o_m_tdata[95] !== 1'b0) begin
                    $error("tdata pad bit: expected 0, got %b", o_m_tdata[95]);
                    n_fail++;
                end
                n_status[want.status]++;
                if (want.unknown_size) n_unknown++;
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            n_accepted = n_accepted + 1;
            parse_ebml_byte(i_s_tdata, i_s_tlast, emit, pred);
            if (emit) expected_hdrs.insert(expected_hdrs.size(), pred);
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the feed, reset, wait for completion
    // ------------------------------------------------------------------
    initial begin
        int kind;
        int ilen;
        int slen;
        clear_parse();

        // Directed part
        add_byte(8'h80, 1'b0); add_byte(8'h81, 1'b1);   // smallest header, last on final byte
        add_byte(8'h00, 1'b1);                          // bad ID byte carrying last
        add_byte(8'h0F, 1'b0);                          // bad ID byte, top of the bad range
        add_byte(8'h1F, 1'b0); add_byte(8'hFF, 1'b0);   // longest ID, longest all-ones size
        add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
        add_byte(8'h01, 1'b0);
        for (int k = 0; k < 7; k++) add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);   // unknown size
        add_byte(8'h42, 1'b0); add_byte(8'h86, 1'b0);   // bad size first byte
        add_byte(8'h00, 1'b0);
        add_byte(8'h1A, 1'b1);                          // truncated inside the ID
        add_byte(8'hA3, 1'b1);                          // truncated right after the ID
        add_byte(8'h81, 1'b0); add_byte(8'h40, 1'b1);   // truncated inside the size

        drain_next = 1'b1;
        while (byte_feed.size() < 925) begin
            kind = $urandom_range(0, 99);
            ilen = $urandom_range(1, 4);
            slen = $urandom_range(1, 8);
            if (byte_feed.size() > 500 && byte_feed.size() < 512) drain_next = 1'b1;
            if (kind < 70) begin
                add_header(ilen, slen, 1'b0,
                           ($urandom_range(0, 7) == 0) ? ilen + slen - 1 : -1, 1'b0);
            end else if (kind < 75) begin
                add_header(ilen, 1, 1'b1, -1, 1'b0);
            end else if (kind < 85) begin
                add_header(ilen, slen, 1'b0, $urandom_range(0, ilen + slen - 2), 1'b0);
            end else if (kind < 90) begin
                add_byte(8'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end else if (kind < 95) begin
                add_header(ilen, 1, 1'b0, ($urandom_range(0, 3) == 0) ? ilen : -1, 1'b1);
            end else begin
                add_byte(8'($urandom), $urandom_range(0, 15) == 0);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (byte_feed.size() != 0 || n_accepted != n_issued || expected_hdrs.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (expected_hdrs.size() != 0) begin
            $error("%0d result items never arrived", expected_hdrs.size());
            n_fail++;
        end
        $display("Parsed %0d bytes into %0d result items: %0d headers (%0d of unknown size),",
                 n_accepted, n_results, n_status[ST_OK], n_unknown);
        $display("%0d bad ID bytes, %0d bad size bytes, %0d truncated headers",
                 n_status[ST_BAD_ID], n_status[ST_BAD_SIZE], n_status[ST_TRUNCATED]);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* ebml_element_header_parser.f */
rtl/ebml_pkg.sv
rtl/ebml_element_header_parser.sv
sim/tb.sv
